[sv/bole_pkg.sv]
// Shared types and codes for the bounded ordered list engine.
`default_nettype none

package bole_pkg;

    // One stored list entry.
    typedef logic signed [31:0] t_word;

    // Operation codes carried in the request.
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_END   = 3'd4,
        OP_REM_AT    = 3'd5
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;   // open a gap at the target index
        logic rem;   // close the gap at the target index
    } t_shift_ctl;

    // Field widths of the request and result, and the request tdata width.
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 48;

endpackage

`default_nettype wire

[sv/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine: decode, cell row and result register.
//
// Channel   Direction  Handshake                         Contents
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready operation request
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready removed value, status, count
//
// Each request is served by all cells shifting in parallel towards or away
// from the target index; one request per clock is accepted unless the output stalls.
// The result sits in a single output register; a new request is taken while
// the previous result is being taken by the consumer in the same cycle.
// A stalled output holds the result and stops further requests.
// Reset (synchronous, active low) empties the list; entry contents are not cleared.
`default_nettype none

module bounded_ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // opcode [2:0], value_in [34:3], position [40:35], zero padding above
    input  wire  [bole_pkg::IN_W-1:0]           i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // value_out [31:0], status [33:32], fill_count [33+CNT_W:34], zero padding above
    output logic [((34+$clog2(CAPACITY+1)+7)/8)*8-1:0] o_m_axis_tdata
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RES_W = VALUE_W + STATUS_W + CNT_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // Request fields.
    logic [OPCODE_W-1:0] w_opcode;
    t_word               w_value_in;
    logic [POS_W-1:0]    w_position;
    logic                w_in_fire;

    assign w_opcode   = i_s_axis_tdata[OPCODE_W-1:0];
    assign w_value_in = i_s_axis_tdata[OPCODE_W+VALUE_W-1:OPCODE_W];
    assign w_position = i_s_axis_tdata[OPCODE_W+VALUE_W+POS_W-1:OPCODE_W+VALUE_W];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [RES_W-1:0] r_out_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    // Decode: pick the target index, shift direction and status.
    t_shift_ctl       w_ctl;
    t_shift_ctl       w_cell_ctl;
    logic [IDX_W-1:0] w_at;
    t_status          w_status;
    logic             w_full;
    logic             w_empty;
    logic             w_pos_bad;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_cnt_x;

    assign w_full    = (r_count == FULL_CNT);
    assign w_empty   = (r_count == '0);
    assign w_pos_x   = CMP_W'(w_position);
    assign w_cnt_x   = CMP_W'(r_count);
    assign w_pos_bad = (w_pos_x >= w_cnt_x);

    always_comb begin
        w_ctl    = '0;
        w_at     = '0;
        w_status = ST_OK;
        n_count  = r_count;
        case (w_opcode)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if ((w_opcode == OP_INS_AT) && w_pos_bad) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                    if (w_opcode == OP_INS_END) begin
                        w_at = IDX_W'(r_count);
                    end else if (w_opcode == OP_INS_AT) begin
                        w_at = IDX_W'(w_pos_x);
                    end
                end
            end
            OP_REM_FRONT, OP_REM_END, OP_REM_AT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if ((w_opcode == OP_REM_AT) && w_pos_bad) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.rem = 1'b1;
                    n_count   = r_count - 1'b1;
                    if (w_opcode == OP_REM_END) begin
                        w_at = IDX_W'(r_count - 1'b1);
                    end else if (w_opcode == OP_REM_AT) begin
                        w_at = IDX_W'(w_pos_x);
                    end
                end
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // Cells move only on an accepted request.
    assign w_cell_ctl = w_in_fire ? w_ctl : '0;

    // Row of cells, head at index zero.
    t_word w_value [CAPACITY];
    t_word w_tap   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
        t_word w_left;
        t_word w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end
        bole_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_cell_ctl),
            .i_at       (w_at),
            .i_value_in (w_value_in),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_value    (w_value[g]),
            .o_tap      (w_tap[g])
        );
    end

    // Removed value: OR of the cell taps, only the target cell contributes.
    t_word w_removed;
    always_comb begin
        w_removed = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_removed = w_removed | w_tap[i];
        end
        if (!w_ctl.rem) begin
            w_removed = '0;
        end
    end

    // Count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_fire) begin
            r_out_data <= {n_count, w_status, w_removed};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);

endmodule

`default_nettype wire

[sv/bole_cell.sv]
// One list cell: holds one entry and shifts it to or from its neighbours.
`default_nettype none

module bole_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  wire                     i_clk,
    input  wire bole_pkg::t_shift_ctl i_ctl,
    input  wire  [IDX_W-1:0]        i_at,
    input  wire bole_pkg::t_word    i_value_in,
    input  wire bole_pkg::t_word    i_left,
    input  wire bole_pkg::t_word    i_right,
    output bole_pkg::t_word         o_value,
    output bole_pkg::t_word         o_tap
);
    import bole_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    t_word r_value;
    t_word n_value;
    logic  w_hit;
    logic  w_after;

    assign w_hit   = (i_at == MY_IDX);
    assign w_after = (i_at < MY_IDX);

    // Choose between holding, loading the new value or taking a neighbour's entry.
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (w_hit) begin
                n_value = i_value_in;
            end else if (w_after) begin
                n_value = i_left;
            end
        end else if (i_ctl.rem) begin
            if (w_hit || w_after) begin
                n_value = i_right;
            end
        end
    end

    // Entry storage needs no reset: only entries below the count are ever read.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // Contribute this entry to the removed-value OR only when it is the target.
    assign o_tap   = w_hit ? r_value : '0;

endmodule

`default_nettype wire

[sv/bole_checker.sv]
// Port-level checks for the bounded ordered list engine, bound to the top level.
`default_nettype none

module bole_port_checks #(
    parameter int CAPACITY = 64
) (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 o_s_axis_tready,
    input wire                                 o_m_axis_tvalid,
    input wire                                 i_m_axis_tready,
    input wire [((34+$clog2(CAPACITY+1)+7)/8)*8-1:0] o_m_axis_tdata
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0]  w_val;
    logic [STATUS_W-1:0] w_st;
    logic [CNT_W-1:0]    w_cnt;

    assign w_val = o_m_axis_tdata[VALUE_W-1:0];
    assign w_st  = o_m_axis_tdata[VALUE_W+STATUS_W-1:VALUE_W];
    assign w_cnt = o_m_axis_tdata[VALUE_W+STATUS_W+CNT_W-1:VALUE_W+STATUS_W];

    // A stalled result stays presented unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // No request is taken while a result is stalled.
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("request taken over a stalled result");

    // The count never passes the capacity.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_cnt <= CNT_W'(CAPACITY)))
        else $error("fill count beyond capacity");

    // An empty report means no entries and no value.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_st == ST_EMPTY) |-> (w_cnt == '0) && (w_val == '0))
        else $error("empty status with entries or value");

    // A full report means the list is at capacity.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_st == ST_FULL) |-> (w_cnt == CNT_W'(CAPACITY)))
        else $error("full status below capacity");

endmodule

bind bounded_ordered_list_engine bole_port_checks #(.CAPACITY(CAPACITY)) u_bole_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

[test/bole_checker.sv]
// Result checker for the bounded ordered list engine: predicts every result and compares it.
`timescale 1ns / 100ps

module bole_checker #(
    parameter int CAPACITY = 64,
    parameter int OUT_W    = 48
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_req_valid,
    input  wire                       i_req_ready,
    // opcode [2:0], value_in [34:3], position [40:35], zero padding above
    input  wire  [bole_pkg::IN_W-1:0] i_req_data,
    input  wire                       i_res_valid,
    input  wire                       i_res_ready,
    // value_out [31:0], status [33:32], fill_count [40:34], zero padding above
    input  wire  [OUT_W-1:0]          i_res_data,
    output int unsigned               o_fail_count,
    output int unsigned               o_pending,
    output int unsigned               o_fill
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        t_word            value;
        t_status          status;
        logic [CNT_W-1:0] fill;
    } t_list_result;

    // Shadow copy of the list, head at index 0.
    t_word        shadow_list [CAPACITY];
    int unsigned  shadow_len;
    t_list_result due_results [$];
    int unsigned  mismatches;

    // Applies one request to the shadow list and returns the result it should give.
    function automatic t_list_result apply_list_op(logic [2:0] op, t_word val, logic [5:0] pos);
        t_list_result res;
        int           at;
        int           i;
        res.value  = '0;
        res.status = ST_OK;
        case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                // The full check takes priority over the position check.
                if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (op == OP_INS_AT && pos >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    if (op == OP_INS_FRONT)
                        at = 0;
                    else if (op == OP_INS_END)
                        at = shadow_len;
                    else
                        at = pos;
                    for (i = shadow_len; i > at; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[at] = val;
                    shadow_len++;
                end
            end
            OP_REM_FRONT, OP_REM_END, OP_REM_AT: begin
                // The empty check takes priority over the position check.
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (op == OP_REM_AT && pos >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    if (op == OP_REM_FRONT)
                        at = 0;
                    else if (op == OP_REM_END)
                        at = shadow_len - 1;
                    else
                        at = pos;
                    res.value = shadow_list[at];
                    for (i = at; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            end
            default: begin
                // Unused opcodes leave the list alone.
            end
        endcase
        res.fill = CNT_W'(shadow_len);
        return res;
    endfunction

    // Predict on each accepted request, then compare each accepted result with the oldest one due.
    always @(posedge i_clk) begin : monitor
        t_list_result want;
        t_list_result got;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                due_results.push_back(apply_list_op(i_req_data[2:0], i_req_data[34:3],
                                                    i_req_data[40:35]));
            if (i_res_valid && i_res_ready) begin
                got.value  = i_res_data[31:0];
                got.status = t_status'(i_res_data[33:32]);
                got.fill   = i_res_data[34 +: CNT_W];
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none due: value %h status %0d fill %0d",
                             $time, got.value, got.status, got.fill);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want)
                        mismatches++;
                    if (got.value !== want.value)
                        $display("%0t: value mismatch: expected %h actual %h",
                                 $time, want.value, got.value);
                    if (got.status !== want.status)
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, got.status);
                    if (got.fill !== want.fill)
                        $display("%0t: fill mismatch: expected %0d actual %0d",
                                 $time, want.fill, got.fill);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= due_results.size();
        o_fill       <= shadow_len;
    end

endmodule

[test/testbench.sv]
// Testbench top for the bounded ordered list engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import bole_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int OUT_W           = ((34 + $clog2(CAPACITY + 1) + 7) / 8) * 8;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int CYCLE_LIMIT     = 200000;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} t_mode;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic               m_tready = 1'b0;
    wire                s_tready;
    wire                m_tvalid;
    wire  [OUT_W-1:0]   m_tdata;
    int unsigned        fail_count;
    int unsigned        pending;
    int unsigned        fill;
    int unsigned        cycles      = 0;
    int                 tx_idle_pct = 9;
    int                 rx_idle_pct = 66;

    bounded_ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    bole_checker #(
        .CAPACITY(CAPACITY),
        .OUT_W   (OUT_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .i_req_ready (s_tready),
        .i_req_data  (s_tdata),
        .i_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .i_res_data  (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_fill      (fill)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog on the run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly ordinary values, now and then an extreme one.
    function automatic t_word rand_value();
        case ($urandom_range(0, 19))
            0:       return t_word'(32'h8000_0000);
            1:       return t_word'(32'h7fff_ffff);
            2:       return t_word'(32'h0000_0000);
            3:       return t_word'(32'hffff_ffff);
            default: return t_word'($urandom);
        endcase
    endfunction

    // Grow phases favour inserts, shrink phases removals, mixed phases anything.
    function automatic logic [2:0] pick_opcode(t_mode mode);
        logic is_ins;
        int   r;
        int   kind;
        r    = $urandom_range(0, 99);
        kind = $urandom_range(0, 2);
        if (mode == MODE_MIXED)
            return 3'($urandom_range(0, 7));
        is_ins = (mode == MODE_GROW) ? (r < 85) : (r >= 85);
        case (kind)
            0:       return is_ins ? OP_INS_FRONT : OP_REM_FRONT;
            1:       return is_ins ? OP_INS_END : OP_REM_END;
            default: return is_ins ? OP_INS_AT : OP_REM_AT;
        endcase
    endfunction

    // Positional requests mostly aim inside the current list.
    function automatic logic [5:0] pick_position(logic [2:0] op);
        if ((op == OP_INS_AT || op == OP_REM_AT) && fill > 0 && $urandom_range(0, 99) < 80)
            return 6'($urandom_range(0, fill - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    // Presents one request after a random gap and waits until it is taken.
    task automatic send_request(logic [2:0] op, t_word val, logic [5:0] pos);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pos, val, op};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Holds requests back until every result due has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_mode      mode;
        logic [2:0] op;
        int         sent;
        int         segment;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Removals from an empty list, and insert at on an empty list.
        send_request(OP_REM_FRONT, rand_value(), 6'd0);
        send_request(OP_REM_END, rand_value(), 6'd63);
        send_request(OP_REM_AT, rand_value(), 6'd0);
        send_request(OP_INS_AT, t_word'(32'h1234_5678), 6'd0);
        // Removing the only element, by position and from the end.
        send_request(OP_INS_END, t_word'(32'h7fff_ffff), 6'd0);
        send_request(OP_REM_AT, rand_value(), 6'd0);
        send_request(OP_INS_FRONT, t_word'(32'h8000_0000), 6'd63);
        send_request(OP_REM_END, rand_value(), 6'd0);
        // Build a short list; insert at position zero acts on the head.
        send_request(OP_INS_END, t_word'(32'h0000_0001), 6'd0);
        send_request(OP_INS_FRONT, t_word'(32'h8000_0000), 6'd0);
        send_request(OP_INS_END, t_word'(32'h7fff_ffff), 6'd0);
        send_request(OP_INS_AT, t_word'(32'h0000_0000), 6'd0);
        send_request(OP_INS_AT, t_word'(32'hffff_ffff), 6'd3);
        // Positions at and beyond the count are out of range.
        send_request(OP_INS_AT, t_word'(32'h5555_5555), 6'd5);
        send_request(OP_REM_AT, t_word'(32'haaaa_aaaa), 6'd63);
        send_request(OP_REM_AT, rand_value(), 6'd5);
        // Spare opcodes do nothing.
        send_request(OP_SPARE_LO, t_word'(32'hffff_ffff), 6'd63);
        send_request(OP_SPARE_HI, t_word'(32'h0000_0000), 6'd0);
        // Take the list apart from the middle, the front and the end.
        send_request(OP_REM_AT, rand_value(), 6'd2);
        send_request(OP_REM_FRONT, rand_value(), 6'd0);
        send_request(OP_REM_END, rand_value(), 6'd0);
        send_request(OP_REM_AT, rand_value(), 6'd1);
        send_request(OP_REM_FRONT, rand_value(), 6'd0);
        send_request(OP_REM_FRONT, rand_value(), 6'd0);

        // Random phases that grow the list towards capacity and shrink it again.
        sent    = 0;
        segment = 0;
        mode    = MODE_GROW;
        while (sent < RANDOM_REQUESTS) begin
            repeat ($urandom_range(40, 110)) begin
                op = pick_opcode(mode);
                send_request(op, rand_value(), pick_position(op));
                if (op != OP_SPARE_LO && op != OP_SPARE_HI)
                    sent++;
            end
            if (segment == 0 && sent >= RANDOM_REQUESTS / 3) begin
                drain();
                tx_idle_pct <= 66;
                rx_idle_pct <= 9;
                segment = 1;
            end else if (segment == 1 && sent >= 2 * RANDOM_REQUESTS / 3) begin
                drain();
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
                segment = 2;
            end
            case (mode)
                MODE_GROW:   mode = MODE_SHRINK;
                MODE_SHRINK: mode = ($urandom_range(0, 3) == 0) ? MODE_MIXED : MODE_GROW;
                default:     mode = MODE_GROW;
            endcase
        end

        // Let the last results out, then give the verdict.
        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
sv/bole_pkg.sv
sv/bole_cell.sv
sv/bounded_ordered_list_engine.sv
sv/bole_checker.sv
test/bole_checker.sv
test/testbench.sv
